>>> design/vertex_dedup_indexer_top_macros.svh
// ----------------------------------------------------------------------------
// Vertex dedup indexer assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef VERTEX_DEDUP_INDEXER_TOP_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define VDI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vertex dedup indexer: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define VDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vertex dedup indexer: next-cycle check failed");

`endif

>>> design/vdi_pkg.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer package
// Shared defaults, register map and the control word sent to the cells.
// ----------------------------------------------------------------------------
package vdi_pkg;

   // Default sizing
   localparam int MAX_WORDS_DEF     = 8;
   localparam int TABLE_ENTRIES_DEF = 1024;
   localparam int NUM_CELLS_DEF     = 32;

   // Vertex words present on the request port
   localparam int IN_WORDS = 8;
   localparam int WORD_W   = 32;

   // Register map
   localparam int         CSR_ADDR_W            = 3;
   localparam logic [2:0] CSR_ADDR_VERTEX_WORDS = 3'd0;
   localparam logic [3:0] VERTEX_WORDS_RESET    = 4'd8;

   // Result index width
   localparam int OUT_IDX_W = 10;

   // Control word broadcast from the sequencer to every cell
   typedef struct packed {
      logic search_start;
      logic scan_en;
      logic wr_en;
   } cell_ctrl_type;

endpackage

>>> design/vertex_dedup_indexer_top.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer
// Maps each vertex to its index in a compacted list of unique vertices.
// ----------------------------------------------------------------------------
// A clear word (req_op = 1) is answered in the cycle after start and leaves
// busy low, so clears can be issued back to back. A lookup word holds busy
// high through the scan, wait and decide states, and its result strobes in
// the cycle busy drops; a new start is taken in that same cycle. Each cell
// holds DEPTH = ceil(TABLE_ENTRIES / NUM_CELLS) entries. A lookup scans one
// bank entry per cycle in every cell at once, then lets the match ripple
// down the chain of NUM_CELLS cells. The result is on the rsp_ ports for
// one cycle only and cannot be stalled. vertex_words may only be written
// while busy is low and no result is pending.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer_top #(
   parameter int MAX_WORDS     = vdi_pkg::MAX_WORDS_DEF,
   parameter int TABLE_ENTRIES = vdi_pkg::TABLE_ENTRIES_DEF,
   parameter int NUM_CELLS     = vdi_pkg::NUM_CELLS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_op,
   input  logic [31:0]                      req_word0,
   input  logic [31:0]                      req_word1,
   input  logic [31:0]                      req_word2,
   input  logic [31:0]                      req_word3,
   input  logic [31:0]                      req_word4,
   input  logic [31:0]                      req_word5,
   input  logic [31:0]                      req_word6,
   input  logic [31:0]                      req_word7,
   // result channel
   output logic                             rsp_strobe,
   output logic [vdi_pkg::OUT_IDX_W-1:0]    rsp_unique_index,
   output logic                             rsp_is_new,
   output logic                             rsp_table_full,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [vdi_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import vdi_pkg::*;

   localparam int DEPTH   = (TABLE_ENTRIES + NUM_CELLS - 1) / NUM_CELLS;
   localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CELL_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int GIDX_W  = $clog2(NUM_CELLS * DEPTH) + 1;
   localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int VW      = MAX_WORDS * WORD_W;

   logic [3:0]              vertex_words_ff;
   logic                    csr_hit;
   logic [IN_WORDS*WORD_W-1:0] req_words;
   cell_ctrl_type           cell_ctrl;
   logic [SLOT_W-1:0]       slot;
   logic [CELL_W-1:0]       wr_sel;
   logic [VW-1:0]           query;
   logic [MAX_WORDS-1:0]    mask;
   logic [COUNT_W-1:0]      count;
   logic [NUM_CELLS:0]      link_found;
   logic [GIDX_W-1:0]       link_idx [NUM_CELLS+1];

   // Register port: single register, no wait states
   assign pready  = 1'b1;
   assign csr_hit = (paddr == CSR_ADDR_VERTEX_WORDS);

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_words_ff <= VERTEX_WORDS_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         vertex_words_ff <= pwdata[3:0];
      end
   end

   assign prdata = csr_hit ? {28'd0, vertex_words_ff} : 32'd0;

   assign req_words = {req_word7, req_word6, req_word5, req_word4,
                       req_word3, req_word2, req_word1, req_word0};

   vdi_ctrl #(
      .MAX_WORDS     (MAX_WORDS),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .NUM_CELLS     (NUM_CELLS),
      .DEPTH         (DEPTH),
      .SLOT_W        (SLOT_W),
      .CELL_W        (CELL_W),
      .GIDX_W        (GIDX_W),
      .COUNT_W       (COUNT_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_words        (req_words),
      .vertex_words     (vertex_words_ff),
      .cell_ctrl        (cell_ctrl),
      .slot             (slot),
      .wr_sel           (wr_sel),
      .query            (query),
      .mask             (mask),
      .count            (count),
      .link_found       (link_found[NUM_CELLS]),
      .link_idx         (link_idx[NUM_CELLS]),
      .rsp_strobe       (rsp_strobe),
      .rsp_unique_index (rsp_unique_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_table_full   (rsp_table_full)
   );

   // Head of the result chain carries no match
   assign link_found[0] = 1'b0;
   assign link_idx[0]   = '0;

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cells
      vdi_cell #(
         .CELL_ID   (c),
         .MAX_WORDS (MAX_WORDS),
         .DEPTH     (DEPTH),
         .SLOT_W    (SLOT_W),
         .CELL_W    (CELL_W),
         .GIDX_W    (GIDX_W),
         .COUNT_W   (COUNT_W)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (cell_ctrl),
         .slot           (slot),
         .wr_sel         (wr_sel),
         .query          (query),
         .mask           (mask),
         .count          (count),
         .link_in_found  (link_found[c]),
         .link_in_idx    (link_idx[c]),
         .link_out_found (link_found[c+1]),
         .link_out_idx   (link_idx[c+1])
      );
   end

endmodule

>>> design/vdi_cell.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer cell
// Holds one bank of stored vertices, scans it against the query and hands
// the first match along the result chain to its neighbor each cycle.
// ----------------------------------------------------------------------------
module vdi_cell #(
   parameter int CELL_ID   = 0,
   parameter int MAX_WORDS = 8,
   parameter int DEPTH     = 32,
   parameter int SLOT_W    = 5,
   parameter int CELL_W    = 5,
   parameter int GIDX_W    = 11,
   parameter int COUNT_W   = 11
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vdi_pkg::cell_ctrl_type                ctrl,
   input  logic [SLOT_W-1:0]                     slot,
   input  logic [CELL_W-1:0]                     wr_sel,
   input  logic [MAX_WORDS*vdi_pkg::WORD_W-1:0]  query,
   input  logic [MAX_WORDS-1:0]                  mask,
   input  logic [COUNT_W-1:0]                    count,
   input  logic                                  link_in_found,
   input  logic [GIDX_W-1:0]                     link_in_idx,
   output logic                                  link_out_found,
   output logic [GIDX_W-1:0]                     link_out_idx
);
   import vdi_pkg::*;

   localparam int VW   = MAX_WORDS * WORD_W;
   localparam int BASE = CELL_ID * DEPTH;

   logic [VW-1:0]     bank_ff [DEPTH];
   logic [VW-1:0]     rd_data_ff;
   logic [SLOT_W-1:0] rd_slot_ff;
   logic              rd_vld_ff;
   logic              own_hit_ff;
   logic [GIDX_W-1:0] own_idx_ff;
   logic              link_found_ff;
   logic [GIDX_W-1:0] link_idx_ff;

   logic [MAX_WORDS-1:0] word_eq;
   logic [GIDX_W-1:0]    gidx;
   logic                 hit;
   logic                 wr_here;

   // Bank write and registered read
   assign wr_here = ctrl.wr_en && (wr_sel == CELL_W'(CELL_ID));

   always_ff @(posedge clock) begin
      if (wr_here) begin
         bank_ff[slot] <= query;
      end
      if (ctrl.scan_en) begin
         rd_data_ff <= bank_ff[slot];
      end
      rd_slot_ff <= slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= ctrl.scan_en;
      end
   end

   // Compare the significant words of the read entry
   for (genvar k = 0; k < MAX_WORDS; k++) begin : g_cmp
      assign word_eq[k] = !mask[k] ||
         (rd_data_ff[k*WORD_W +: WORD_W] == query[k*WORD_W +: WORD_W]);
   end

   assign gidx = GIDX_W'(BASE) + GIDX_W'(rd_slot_ff);
   assign hit  = rd_vld_ff && (gidx < GIDX_W'(count)) && (&word_eq);

   // Keep the lowest matching entry of this bank
   always_ff @(posedge clock) begin
      if (reset) begin
         own_hit_ff <= 1'b0;
      end else if (ctrl.search_start) begin
         own_hit_ff <= 1'b0;
      end else if (hit && !own_hit_ff) begin
         own_hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hit && !own_hit_ff) begin
         own_idx_ff <= gidx;
      end
   end

   // Pass the result down the chain: an upstream match wins
   always_ff @(posedge clock) begin
      if (reset) begin
         link_found_ff <= 1'b0;
      end else begin
         link_found_ff <= link_in_found || own_hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      link_idx_ff <= link_in_found ? link_in_idx : own_idx_ff;
   end

   assign link_out_found = link_found_ff;
   assign link_out_idx   = link_idx_ff;

endmodule

>>> design/vdi_ctrl.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer sequencer
// Canonicalizes the vertex, steps the bank scan, waits out the result
// chain, then reports the match, appends the vertex or flags a full table.
// ----------------------------------------------------------------------------
module vdi_ctrl #(
   parameter int MAX_WORDS     = 8,
   parameter int TABLE_ENTRIES = 1024,
   parameter int NUM_CELLS     = 32,
   parameter int DEPTH         = 32,
   parameter int SLOT_W        = 5,
   parameter int CELL_W        = 5,
   parameter int GIDX_W        = 11,
   parameter int COUNT_W       = 11
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                start,
   output logic                                                busy,
   input  logic                                                req_op,
   input  logic [vdi_pkg::IN_WORDS*vdi_pkg::WORD_W-1:0]        req_words,
   input  logic [3:0]                                          vertex_words,
   output vdi_pkg::cell_ctrl_type                              cell_ctrl,
   output logic [SLOT_W-1:0]                                   slot,
   output logic [CELL_W-1:0]                                   wr_sel,
   output logic [MAX_WORDS*vdi_pkg::WORD_W-1:0]                query,
   output logic [MAX_WORDS-1:0]                                mask,
   output logic [COUNT_W-1:0]                                  count,
   input  logic                                                link_found,
   input  logic [GIDX_W-1:0]                                   link_idx,
   output logic                                                rsp_strobe,
   output logic [vdi_pkg::OUT_IDX_W-1:0]                       rsp_unique_index,
   output logic                                                rsp_is_new,
   output logic                                                rsp_table_full
);
   import vdi_pkg::*;

   localparam int VW     = MAX_WORDS * WORD_W;
   localparam int WAIT_W = $clog2(NUM_CELLS + 1);

   localparam logic [31:0] ABS_MASK  = 32'h7FFF_FFFF;
   localparam logic [31:0] EXP_MASK  = 32'h7F80_0000;
   localparam logic [31:0] MAN_MASK  = 32'h007F_FFFF;
   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_DECIDE = 4'b1000
   } state_type;

   function automatic logic [31:0] canon_word(input logic [31:0] b);
      logic [31:0] r;
      r = b;
      if ((b & ABS_MASK) == 32'd0) begin
         r = 32'd0;
      end else if (((b & EXP_MASK) == EXP_MASK) && ((b & MAN_MASK) != 32'd0)) begin
         r = CANON_NAN;
      end
      return r;
   endfunction

   state_type            state_ff, state_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]    ins_slot_ff, ins_slot_in;
   logic [CELL_W-1:0]    ins_sel_ff, ins_sel_in;
   logic [VW-1:0]        query_ff, query_in;
   logic [MAX_WORDS-1:0] mask_ff, mask_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [OUT_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                 rsp_new_ff, rsp_new_in;
   logic                 rsp_full_ff, rsp_full_in;

   logic [VW-1:0]           query_canon;
   logic [MAX_WORDS-1:0]    mask_new;
   logic [3:0]              n_words;
   logic [GIDX_W+9:0]       found_pad;
   logic [COUNT_W+9:0]      count_pad;

   // Canonicalize the incoming words; words past the port read as zero
   for (genvar k = 0; k < MAX_WORDS; k++) begin : g_canon
      if (k < IN_WORDS) begin : g_port
         assign query_canon[k*WORD_W +: WORD_W] = canon_word(req_words[k*WORD_W +: WORD_W]);
      end else begin : g_zero
         assign query_canon[k*WORD_W +: WORD_W] = '0;
      end
   end

   // Clamp the word count and build the compare mask
   always_comb begin
      n_words = vertex_words;
      if (vertex_words == 4'd0) begin
         n_words = 4'd1;
      end else if (vertex_words > 4'(MAX_WORDS)) begin
         n_words = 4'(MAX_WORDS);
      end
   end

   for (genvar k = 0; k < MAX_WORDS; k++) begin : g_mask
      assign mask_new[k] = (4'(k) < n_words);
   end

   assign found_pad = {10'd0, link_idx};
   assign count_pad = {10'd0, count_ff};

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      wait_in       = wait_ff;
      count_in      = count_ff;
      ins_slot_in   = ins_slot_ff;
      ins_sel_in    = ins_sel_ff;
      query_in      = query_ff;
      mask_in       = mask_ff;
      rsp_strobe_in = 1'b0;
      rsp_idx_in    = rsp_idx_ff;
      rsp_new_in    = 1'b0;
      rsp_full_in   = 1'b0;
      cell_ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_op) begin
                  // Empty the store; entries are masked by the count
                  count_in      = '0;
                  ins_slot_in   = '0;
                  ins_sel_in    = '0;
                  rsp_strobe_in = 1'b1;
                  rsp_idx_in    = '0;
               end else begin
                  query_in               = query_canon;
                  mask_in                = mask_new;
                  slot_in                = '0;
                  cell_ctrl.search_start = 1'b1;
                  state_in               = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cell_ctrl.scan_en = 1'b1;
            if (slot_ff == SLOT_W'(DEPTH - 1)) begin
               wait_in  = '0;
               state_in = ST_WAIT;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         ST_WAIT: begin
            // Let the last bank result ripple to the chain end
            if (wait_ff == WAIT_W'(NUM_CELLS)) begin
               state_in = ST_DECIDE;
            end else begin
               wait_in = wait_ff + WAIT_W'(1);
            end
         end
         ST_DECIDE: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            priority if (link_found) begin
               rsp_idx_in = found_pad[OUT_IDX_W-1:0];
            end else if (count_ff == COUNT_W'(TABLE_ENTRIES)) begin
               rsp_idx_in  = '0;
               rsp_full_in = 1'b1;
            end else begin
               // Append at the next free place
               cell_ctrl.wr_en = 1'b1;
               rsp_idx_in      = count_pad[OUT_IDX_W-1:0];
               rsp_new_in      = 1'b1;
               count_in        = count_ff + COUNT_W'(1);
               if (ins_slot_ff == SLOT_W'(DEPTH - 1)) begin
                  ins_slot_in = '0;
                  ins_sel_in  = ins_sel_ff + CELL_W'(1);
               end else begin
                  ins_slot_in = ins_slot_ff + SLOT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         ins_slot_ff   <= '0;
         ins_sel_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ins_slot_ff   <= ins_slot_in;
         ins_sel_ff    <= ins_sel_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      wait_ff     <= wait_in;
      query_ff    <= query_in;
      mask_ff     <= mask_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign slot             = (state_ff == ST_DECIDE) ? ins_slot_ff : slot_ff;
   assign wr_sel           = ins_sel_ff;
   assign query            = query_ff;
   assign mask             = mask_ff;
   assign count            = count_ff;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_unique_index = rsp_idx_ff;
   assign rsp_is_new       = rsp_new_ff;
   assign rsp_table_full   = rsp_full_ff;

endmodule

>>> design/vdi_checker.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer port checker
// Watches the request and result ports of the top level over time.
// ----------------------------------------------------------------------------
`include "vertex_dedup_indexer_top_macros.svh"

module vdi_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_op,
   input logic       rsp_strobe,
   input logic [9:0] rsp_unique_index,
   input logic       rsp_is_new,
   input logic       rsp_table_full
);

   logic clear_taken;
   logic lookup_taken;
   logic empty_result;
   logic zero_not_new;

   // Decode accepted words and result shapes
   assign clear_taken  = start && !busy && req_op;
   assign lookup_taken = start && !busy && !req_op;
   assign zero_not_new = (rsp_unique_index == 10'd0) && !rsp_is_new;
   assign empty_result = rsp_strobe && zero_not_new && !rsp_table_full;

   // A clear word is answered in the next cycle with an empty result
   `VDI_ASSERT_NEXT(a_clear_answer, clock, reset, clear_taken, empty_result)

   // A lookup word makes the block busy
   `VDI_ASSERT_NEXT(a_lookup_busy, clock, reset, lookup_taken, busy)

   // The end of a lookup delivers its result
   `VDI_ASSERT_NOW(a_done_strobe, clock, reset, $fell(busy), rsp_strobe)

   // No result is shown while a lookup is in flight
   `VDI_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy)

   // An overflow result carries index zero and no new flag
   `VDI_ASSERT_NOW(a_full_result, clock, reset, rsp_strobe && rsp_table_full, zero_not_new)

endmodule

bind vertex_dedup_indexer_top vdi_checker u_vdi_checker (.*);
